FILE: rtl/flvp_pkg.sv
// Shared types and constants for the FLV tag stream parser.
package flvp_pkg;

  typedef enum logic [1:0] {
    PH_FILE,
    PH_TAGHDR,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  localparam logic [1:0] KIND_DESC = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_SIG   = 3'd0;
  localparam logic [2:0] ERR_HDR   = 3'd1;
  localparam logic [2:0] ERR_AUDIO = 3'd2;
  localparam logic [2:0] ERR_VIDEO = 3'd3;
  localparam logic [2:0] ERR_KEY   = 3'd4;

  localparam logic [2:0] CODEC_AAC  = 3'd0;
  localparam logic [2:0] CODEC_OPUS = 3'd1;
  localparam logic [2:0] CODEC_AVC  = 3'd2;
  localparam logic [2:0] CODEC_HEVC = 3'd3;
  localparam logic [2:0] CODEC_VP8  = 3'd4;
  localparam logic [2:0] CODEC_VP9  = 3'd5;

  localparam logic [2:0] CFG_AAC  = 3'd0;
  localparam logic [2:0] CFG_OPUS = 3'd1;
  localparam logic [2:0] CFG_AVC  = 3'd2;
  localparam logic [2:0] CFG_HEVC = 3'd3;
  localparam logic [2:0] CFG_VP8  = 3'd4;
  localparam logic [2:0] CFG_VP9  = 3'd5;

  localparam logic [7:0] SIG_F      = 8'h46;
  localparam logic [7:0] SIG_L      = 8'h4c;
  localparam logic [7:0] SIG_V      = 8'h56;
  localparam logic [7:0] DATA_OFS   = 8'd9;
  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [3:0] FRAME_KEY  = 4'd1;
  localparam logic [23:0] HDR_AUDIO = 24'd2;
  localparam logic [23:0] HDR_VIDEO = 24'd5;

  typedef struct packed {
    logic [3:0] aac;
    logic [3:0] opus;
    logic [3:0] avc;
    logic [3:0] hevc;
    logic [3:0] vp8;
    logic [3:0] vp9;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        is_video;
    logic [2:0]  codec;
    logic        seq_header;
    logic        key_frame;
    logic [31:0] decode_time;
    logic [31:0] present_time;
    logic [23:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [2:0]  error_code;
  } res_t;

endpackage

FILE: rtl/flvp_core.sv
// Byte-level FLV parse state and per-byte result generation.
module flvp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_acc,
  input  logic [7:0]          stream_byte,
  input  flvp_pkg::cfg_t      cfg,
  output logic                res_vld,
  output flvp_pkg::res_t      res
);

  flvp_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] idx_r, idx_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [23:0] size_r, size_nxt;
  logic [31:0] time_r, time_nxt;
  logic [7:0]  fmt_r, fmt_nxt;
  logic [7:0]  pk_r, pk_nxt;
  logic [23:0] comp_r, comp_nxt;
  logic        stopped_r, stopped_nxt;

  logic        video, media, last, keytype, err_hit;
  logic [2:0]  err_code;
  logic [23:0] hdr;
  logic [24:0] idx_inc;
  logic [3:0]  anib, vnib;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    kind_nxt    = kind_r;
    size_nxt    = size_r;
    time_nxt    = time_r;
    fmt_nxt     = fmt_r;
    pk_nxt      = pk_r;
    comp_nxt    = comp_r;
    stopped_nxt = stopped_r;
    res         = '0;
    res_vld     = 1'b0;
    err_hit     = 1'b0;
    err_code    = flvp_pkg::ERR_SIG;
    video       = (kind_r == flvp_pkg::TAG_VIDEO);
    media       = video || (kind_r == flvp_pkg::TAG_AUDIO);
    hdr         = video ? flvp_pkg::HDR_VIDEO : flvp_pkg::HDR_AUDIO;
    idx_inc     = {1'b0, idx_r} + 25'd1;
    last        = (idx_inc >= {1'b0, size_r});
    anib        = stream_byte[7:4];
    vnib        = stream_byte[3:0];
    keytype     = 1'b0;

    if (!stopped_r) begin
      case (phase_r)
        flvp_pkg::PH_FILE: begin
          if ((idx_r == 24'd0 && stream_byte != flvp_pkg::SIG_F) ||
              (idx_r == 24'd1 && stream_byte != flvp_pkg::SIG_L) ||
              (idx_r == 24'd2 && stream_byte != flvp_pkg::SIG_V)) begin
            err_hit  = 1'b1;
            err_code = flvp_pkg::ERR_SIG;
          end else if ((idx_r >= 24'd5 && idx_r <= 24'd7 && stream_byte != 8'd0) ||
                       (idx_r == 24'd8 && stream_byte != flvp_pkg::DATA_OFS)) begin
            err_hit  = 1'b1;
            err_code = flvp_pkg::ERR_HDR;
          end else if (idx_r >= 24'd12) begin
            phase_nxt = flvp_pkg::PH_TAGHDR;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc[23:0];
          end
        end
        flvp_pkg::PH_TAGHDR: begin
          if (idx_r == 24'd0) begin
            kind_nxt = stream_byte;
            size_nxt = '0;
            time_nxt = '0;
            comp_nxt = '0;
            fmt_nxt  = '0;
            pk_nxt   = '0;
          end else if (idx_r <= 24'd3) begin
            size_nxt = {size_r[15:0], stream_byte};
          end else if (idx_r <= 24'd6) begin
            time_nxt = {8'd0, time_r[15:0], stream_byte};
          end else if (idx_r == 24'd7) begin
            time_nxt = {stream_byte, time_r[23:0]};
          end
          if (idx_r >= 24'd10) begin
            phase_nxt = (size_r == 24'd0) ? flvp_pkg::PH_TRAIL : flvp_pkg::PH_DATA;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc[23:0];
          end
        end
        flvp_pkg::PH_DATA: begin
          if (media) begin
            if (idx_r == 24'd0) begin
              fmt_nxt = stream_byte;
              if (!video && anib != cfg.aac && anib != cfg.opus) begin
                err_hit  = 1'b1;
                err_code = flvp_pkg::ERR_AUDIO;
              end else if (video && vnib != cfg.avc && vnib != cfg.hevc &&
                           vnib != cfg.vp8 && vnib != cfg.vp9) begin
                err_hit  = 1'b1;
                err_code = flvp_pkg::ERR_VIDEO;
              end
            end else if (idx_r == 24'd1) begin
              pk_nxt = stream_byte;
              if (video && fmt_r[7:4] == flvp_pkg::FRAME_KEY && stream_byte > 8'd1) begin
                err_hit  = 1'b1;
                err_code = flvp_pkg::ERR_KEY;
              end
            end else if (video && idx_r < 24'd5) begin
              comp_nxt = {comp_r[15:0], stream_byte};
            end else begin
              res_vld          = 1'b1;
              res.result_kind  = flvp_pkg::KIND_PAY;
              res.payload_byte = stream_byte;
              res.last_byte    = last;
            end
            // descriptor goes out on the final media header byte when payload bytes follow
            if (idx_inc == {1'b0, hdr} && size_r > hdr) begin
              keytype            = (fmt_nxt[7:4] == flvp_pkg::FRAME_KEY);
              res                = '0;
              res_vld            = 1'b1;
              res.result_kind    = flvp_pkg::KIND_DESC;
              res.is_video       = video;
              res.decode_time    = time_r;
              res.present_time   = time_r + {8'd0, comp_nxt};
              res.payload_length = size_r - hdr;
              if (video) begin
                if (fmt_nxt[3:0] == cfg.avc)       res.codec = flvp_pkg::CODEC_AVC;
                else if (fmt_nxt[3:0] == cfg.hevc) res.codec = flvp_pkg::CODEC_HEVC;
                else if (fmt_nxt[3:0] == cfg.vp8)  res.codec = flvp_pkg::CODEC_VP8;
                else                               res.codec = flvp_pkg::CODEC_VP9;
                res.seq_header = keytype && (pk_nxt == 8'd0);
                res.key_frame  = keytype && (pk_nxt == 8'd1);
              end else begin
                res.codec      = (fmt_nxt[7:4] == cfg.aac) ? flvp_pkg::CODEC_AAC
                                                           : flvp_pkg::CODEC_OPUS;
                res.seq_header = (pk_nxt == 8'd0);
              end
            end
          end
          if (last) begin
            phase_nxt = flvp_pkg::PH_TRAIL;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc[23:0];
          end
        end
        flvp_pkg::PH_TRAIL: begin
          if (idx_r >= 24'd3) begin
            phase_nxt = flvp_pkg::PH_TAGHDR;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc[23:0];
          end
        end
        default: begin
          phase_nxt = flvp_pkg::PH_FILE;
        end
      endcase

      if (err_hit) begin
        res             = '0;
        res_vld         = 1'b1;
        res.result_kind = flvp_pkg::KIND_ERR;
        res.error_code  = err_code;
        stopped_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= flvp_pkg::PH_FILE;
      idx_r     <= '0;
      kind_r    <= '0;
      size_r    <= '0;
      time_r    <= '0;
      fmt_r     <= '0;
      pk_r      <= '0;
      comp_r    <= '0;
      stopped_r <= 1'b0;
    end else if (byte_acc) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      kind_r    <= kind_nxt;
      size_r    <= size_nxt;
      time_r    <= time_nxt;
      fmt_r     <= fmt_nxt;
      pk_r      <= pk_nxt;
      comp_r    <= comp_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

FILE: rtl/flv_tag_stream_parser_top.sv
// Top level of the FLV tag stream parser: config registers and output stage.
//
//  channel | dir | width             | content
//  in_     | in  | tdata 8           | one stream byte per transaction
//  out_    | out | tdata 112, user 2 | descriptor, payload byte or error code
//  cfg_    | in  | index 3, data 4   | codec nibble registers, write only
//
// One byte per cycle while in_tready is high; the parse state and the result register
// update in the same cycle a byte is accepted, so a result appears in the cycle after its byte.
// in_tready drops only while a result sits in the output register unaccepted.
// rst_n is synchronous; an error result stops parsing until the next reset.
module flv_tag_stream_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] is_video, [3:1] codec, [4] seq_header, [5] key_frame,
  // [37:6] decode_time, [69:38] present_time, [93:70] payload_length,
  // [101:94] payload_byte, [104:102] error_code, [111:105] zero
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast,  // last_byte
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  flvp_pkg::cfg_t cfg_r;
  flvp_pkg::res_t res, out_res_r;
  logic           res_vld, in_acc, out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.aac  <= 4'd10;
      cfg_r.opus <= 4'd13;
      cfg_r.avc  <= 4'd7;
      cfg_r.hevc <= 4'd12;
      cfg_r.vp8  <= 4'd13;
      cfg_r.vp9  <= 4'd14;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        flvp_pkg::CFG_AAC:  cfg_r.aac  <= cfg_data;
        flvp_pkg::CFG_OPUS: cfg_r.opus <= cfg_data;
        flvp_pkg::CFG_AVC:  cfg_r.avc  <= cfg_data;
        flvp_pkg::CFG_HEVC: cfg_r.hevc <= cfg_data;
        flvp_pkg::CFG_VP8:  cfg_r.vp8  <= cfg_data;
        flvp_pkg::CFG_VP9:  cfg_r.vp9  <= cfg_data;
        default: ;
      endcase
    end
  end

  flvp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (in_acc),
    .stream_byte (in_tdata),
    .cfg         (cfg_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_vld;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.result_kind;
  assign out_tlast  = out_res_r.last_byte;
  assign out_tdata  = {7'd0, out_res_r.error_code, out_res_r.payload_byte,
                       out_res_r.payload_length, out_res_r.present_time,
                       out_res_r.decode_time, out_res_r.key_frame,
                       out_res_r.seq_header, out_res_r.codec, out_res_r.is_video};

endmodule

FILE: rtl/flvp_checker.sv
// Port-level assertions for the FLV tag stream parser, bound to the top level.
module flvp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == flvp_pkg::KIND_DESC || out_tuser == flvp_pkg::KIND_PAY ||
                    out_tuser == flvp_pkg::KIND_ERR))
    else $error("illegal result kind");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == flvp_pkg::KIND_PAY)
    else $error("last mark on non-payload transaction");

  // parser is stopped after an error, nothing follows it
  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == flvp_pkg::KIND_ERR |=> !out_tvalid)
    else $error("result after error");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

endmodule

bind flv_tag_stream_parser_top flvp_checker u_flvp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
